>>> rtl/rpot_pkg.sv
package rpot_pkg;

   localparam int PortCountDefault = 16;
   localparam int TimeW = 48;
   localparam int LenW = 32;
   localparam int BwW = 40;
   localparam int HopW = 32;
   localparam int ProdW = 62;   // 32-bit length times 1e9 fits in 62 bits
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 40;
   localparam int QueueDepth = 2;

   localparam logic [29:0] NsPerSec = 30'd1000000000;
   localparam logic [TimeW-1:0] Max48 = {TimeW{1'b1}};

   localparam logic [CsrIdxW-1:0] CSR_AGGREGATOR = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_HOP_DELAY = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_BANDWIDTH = 2'd2;

   localparam logic [1:0] DISP_FORWARD = 2'd0;
   localparam logic [1:0] DISP_DEFER = 2'd1;
   localparam logic [1:0] DISP_AGGREGATE = 2'd2;

   typedef struct packed {
      logic [3:0] arrival_port;
      logic [3:0] exit_port;
      logic [31:0] length_bytes;
      logic [47:0] now_time;
      logic is_local;
      logic [15:0] tally_events_in;
      logic [47:0] tally_time_in;
   } req_type;

   typedef struct packed {
      logic [1:0] disposition;
      logic [3:0] target_port;
      logic [47:0] send_delay;
      logic [15:0] tally_events_out;
      logic [47:0] tally_time_out;
   } rsp_type;

   // front-end classification handed to the back end
   typedef struct packed {
      req_type req;
      logic aggregate;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_DIV,
      ST_FINISH
   } back_state_type;

   function automatic logic [TimeW-1:0] sat_add48(input logic [TimeW-1:0] a,
                                                  input logic [TimeW-1:0] b);
      logic [TimeW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TimeW] ? Max48 : s[TimeW-1:0];
   endfunction

   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

>>> rtl/rpot_front.sv
module rpot_front
   import rpot_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  req_type req_data,
   input  logic agg_mode,
   output logic job_valid,
   input  logic job_take,
   output job_type job
);

   logic [QueueDepth-1:0] valid_ff, valid_in;
   job_type slot_ff [QueueDepth];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic push_ok;

   assign req_full = valid_ff[wr_ptr_ff];
   assign push_ok = req_push && !req_full;
   assign job_valid = valid_ff[rd_ptr_ff];
   assign job = slot_ff[rd_ptr_ff];

   // two-entry queue between front and back
   always_comb begin
      valid_in = valid_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (job_take && job_valid) begin
         valid_in[rd_ptr_ff] = 1'b0;
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push_ok) begin
         valid_in[wr_ptr_ff] = 1'b1;
         wr_ptr_in = !wr_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // classify at entry: aggregator pass needs no timing work
   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff].req <= req_data;
         slot_ff[wr_ptr_ff].aggregate <= agg_mode;
      end
   end

endmodule

>>> rtl/rpot_div.sv
module rpot_div
   import rpot_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [ProdW-1:0] dividend,
   input  logic [BwW-1:0] divisor,
   output logic busy,
   output logic [ProdW-1:0] quotient
);

   logic [ProdW-1:0] quo_ff, quo_in;
   logic [BwW-1:0] rem_ff, rem_in;
   logic [BwW-1:0] dvs_ff, dvs_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [BwW:0] trial;

   assign busy = cnt_ff != 7'd0;
   assign quotient = quo_ff;

   // restoring division, one quotient bit per cycle
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      trial = {rem_ff, quo_ff[ProdW-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = 7'(ProdW);
      end else if (busy) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = BwW'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[ProdW-2:0], 1'b1};
         end else begin
            rem_in = trial[BwW-1:0];
            quo_in = {quo_ff[ProdW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

>>> rtl/rpot_back.sv
module rpot_back
   import rpot_pkg::*;
#(
   parameter int PORT_COUNT = PortCountDefault
)(
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_take,
   input  job_type job,
   input  logic [HopW-1:0] router_lat,
   input  logic [BwW-1:0] bandwidth,
   output logic rsp_empty,
   input  logic rsp_pop,
   output rsp_type rsp_data
);

   localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

   back_state_type state_ff, state_in;
   job_type cur_ff, cur_in;
   logic [ProdW-1:0] prod_ff, prod_in;
   logic [PW-1:0] ip_ff, ip_in, op_ff, op_in;
   logic [TimeW-1:0] blocked_ff, blocked_in;
   logic [15:0] tev_ff, tev_in;
   logic [TimeW-1:0] ttm_ff, ttm_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [TimeW-1:0] input_free_at_ff [PORT_COUNT];
   logic [TimeW-1:0] output_free_at_ff [PORT_COUNT];
   logic [31:0] accepted_per_port_ff [PORT_COUNT];
   logic [31:0] sent_per_port_ff [PORT_COUNT];
   logic [31:0] message_total_ff, local_message_total_ff;
   logic [31:0] input_stall_events_ff, output_stall_events_ff;
   logic [TimeW-1:0] input_stall_time_ff, output_stall_time_ff, total_router_delay_ff;

   logic div_start, div_busy;
   logic [ProdW-1:0] quotient;
   logic [TimeW-1:0] link, t_base, in_free, out_free, hop48;
   logic [PW-1:0] ip_n, op_n;
   logic take_defer, do_update;
   logic [TimeW-1:0] wait_t, blk_t;

   // fold a 4-bit port field onto the port range (constant lookup)
   function automatic logic [PW-1:0] port_index(input logic [3:0] v);
      logic [PW-1:0] r;
      r = '0;
      for (int i = 0; i < 16; i++) begin
         if (v == 4'(i)) r = PW'(i % PORT_COUNT);
      end
      return r;
   endfunction

   rpot_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(prod_ff), .divisor(bandwidth),
      .busy(div_busy), .quotient(quotient)
   );

   assign ip_n = port_index(job.req.arrival_port);
   assign op_n = port_index(job.req.exit_port);
   assign in_free = input_free_at_ff[ip_n];
   assign out_free = output_free_at_ff[op_n];
   assign wait_t = in_free - job.req.now_time;
   assign blk_t = out_free - job.req.now_time;
   assign hop48 = TimeW'(router_lat);
   assign link = (bandwidth == '0 || quotient[ProdW-1:TimeW] != '0) ? Max48
                                                                      : quotient[TimeW-1:0];
   assign t_base = sat_add48(cur_ff.req.now_time, blocked_ff);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // sequencer: accept job; answer aggregator or deferred jobs directly, else multiply, divide, commit
   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      prod_in = prod_ff;
      ip_in = ip_ff;
      op_in = op_ff;
      blocked_in = blocked_ff;
      tev_in = tev_ff;
      ttm_in = ttm_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      job_take = 1'b0;
      div_start = 1'b0;
      take_defer = 1'b0;
      do_update = 1'b0;
      if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid && (!rsp_valid_ff || rsp_pop)) begin
               job_take = 1'b1;
               rsp_valid_in = 1'b1;
               if (job.aggregate) begin
                  rsp_in.disposition = DISP_AGGREGATE;
                  rsp_in.target_port = 4'(op_n);
                  rsp_in.send_delay = '0;
                  rsp_in.tally_events_out = job.req.tally_events_in;
                  rsp_in.tally_time_out = job.req.tally_time_in;
               end else if (in_free > job.req.now_time) begin
                  take_defer = 1'b1;
                  rsp_in.disposition = DISP_DEFER;
                  rsp_in.target_port = 4'(ip_n);
                  rsp_in.send_delay = wait_t;
                  rsp_in.tally_events_out = sat_inc16(job.req.tally_events_in);
                  rsp_in.tally_time_out = sat_add48(job.req.tally_time_in, wait_t);
               end else begin
                  rsp_valid_in = 1'b0;
                  cur_in = job;
                  ip_in = ip_n;
                  op_in = op_n;
                  if (out_free > job.req.now_time) begin
                     blocked_in = blk_t;
                     tev_in = sat_inc16(job.req.tally_events_in);
                     ttm_in = sat_add48(job.req.tally_time_in, blk_t);
                  end else begin
                     blocked_in = '0;
                     tev_in = job.req.tally_events_in;
                     ttm_in = job.req.tally_time_in;
                  end
                  state_in = ST_MULT;
               end
            end
         end
         ST_MULT: begin
            prod_in = ProdW'(cur_ff.req.length_bytes) * ProdW'(NsPerSec);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!div_busy && !rsp_valid_ff) begin
               do_update = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in.disposition = DISP_FORWARD;
               rsp_in.target_port = 4'(op_ff);
               rsp_in.send_delay = sat_add48(hop48, blocked_ff);
               rsp_in.tally_events_out = tev_ff;
               rsp_in.tally_time_out = ttm_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      prod_ff <= prod_in;
      ip_ff <= ip_in;
      op_ff <= op_in;
      blocked_ff <= blocked_in;
      tev_ff <= tev_in;
      ttm_ff <= ttm_in;
      rsp_ff <= rsp_in;
   end

   // port timing and statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PORT_COUNT; i++) begin
            input_free_at_ff[i] <= '0;
            output_free_at_ff[i] <= '0;
            accepted_per_port_ff[i] <= '0;
            sent_per_port_ff[i] <= '0;
         end
         message_total_ff <= '0;
         local_message_total_ff <= '0;
         input_stall_events_ff <= '0;
         output_stall_events_ff <= '0;
         input_stall_time_ff <= '0;
         output_stall_time_ff <= '0;
         total_router_delay_ff <= '0;
      end else begin
         if (take_defer) begin
            input_stall_events_ff <= input_stall_events_ff + 32'd1;
            input_stall_time_ff <= sat_add48(input_stall_time_ff, wait_t);
         end
         if (do_update) begin
            accepted_per_port_ff[ip_ff] <= accepted_per_port_ff[ip_ff] + 32'd1;
            sent_per_port_ff[op_ff] <= sent_per_port_ff[op_ff] + 32'd1;
            message_total_ff <= message_total_ff + 32'd1;
            if (cur_ff.req.is_local) begin
               local_message_total_ff <= local_message_total_ff + 32'd1;
            end
            if (blocked_ff != '0) begin
               output_stall_events_ff <= output_stall_events_ff + 32'd1;
               output_stall_time_ff <= sat_add48(output_stall_time_ff, blocked_ff);
            end
            total_router_delay_ff <= sat_add48(total_router_delay_ff,
                                               sat_add48(ttm_ff, hop48));
            output_free_at_ff[op_ff] <= sat_add48(sat_add48(t_base, hop48), link);
            input_free_at_ff[ip_ff] <= sat_add48(t_base, link);
         end
      end
   end

   // a result is never overwritten while it waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pop |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("pending result changed");
   // commit only happens once the divider is done
   assert property (@(posedge clock) disable iff (reset)
      do_update |-> !div_busy && state_ff == ST_FINISH)
      else $error("commit during divide");
   // a job is taken only from idle
   assert property (@(posedge clock) disable iff (reset)
      job_take |-> state_ff == ST_IDLE && job_valid)
      else $error("job taken while busy");

endmodule

>>> rtl/router_port_occupancy_timer_core.sv
// Channel | Ports                              | Transfer when
// req     | req_push, req_full, req_data       | req_push && !req_full
// rsp     | rsp_pop, rsp_empty, rsp_data       | rsp_pop && !rsp_empty
// csr     | csr_we, csr_index, csr_wdata       | csr_we
//
// A forwarded message's result is ready once the one-bit-per-cycle 62-bit divider
// has computed the wire time; deferred and aggregator results are answered from
// the idle state without the divider.
// A two-entry queue parts input acceptance from the timing sequencer.
// Reset is synchronous and clears all port times and counters at once.
// The sequencer waits for a pending result to be popped before finishing.
module router_port_occupancy_timer_core
   import rpot_pkg::*;
#(
   parameter int PORT_COUNT = PortCountDefault
)(
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  req_type req_data,
   output logic rsp_empty,
   input  logic rsp_pop,
   output rsp_type rsp_data,
   input  logic csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   logic agg_ff;
   logic [HopW-1:0] hop_ff;
   logic [BwW-1:0] bw_ff;
   logic job_valid, job_take;
   job_type job;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         agg_ff <= 1'b0;
         hop_ff <= '0;
         bw_ff <= BwW'(1);
      end else if (csr_we) begin
         priority case (csr_index)
            CSR_AGGREGATOR: agg_ff <= csr_wdata[0];
            CSR_HOP_DELAY: hop_ff <= csr_wdata[HopW-1:0];
            CSR_BANDWIDTH: bw_ff <= csr_wdata[BwW-1:0];
            default: ;
         endcase
      end
   end

   rpot_front u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_data(req_data), .agg_mode(agg_ff), .job_valid(job_valid),
      .job_take(job_take), .job(job)
   );

   rpot_back #(.PORT_COUNT(PORT_COUNT)) u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job_take(job_take),
      .job(job), .router_lat(hop_ff), .bandwidth(bw_ff), .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

endmodule
